@@ hdl/gsfc_pkg.sv @@
// ----------------------------------------------------------------------------
// Gas sensor frame checker package
// Shared types and constants for the reply-frame checker.
// ----------------------------------------------------------------------------
package gsfc_pkg;

  localparam int FRAME_BYTES = 9;
  localparam int IDX_W       = $clog2(FRAME_BYTES);

  localparam logic [7:0] HDR_START = 8'hFF;
  localparam logic [7:0] HDR_CMD   = 8'h86;

  localparam logic [15:0] TIMEOUT_RESET = 16'd200;
  localparam logic [15:0] PPM_MIN_RESET = 16'd300;
  localparam logic [15:0] PPM_MAX_RESET = 16'd10000;

  localparam logic [1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_PPM_MIN = 2'd1;
  localparam logic [1:0] CFG_PPM_MAX = 2'd2;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_TIMEOUT      = 3'd1,
    ST_BAD_HEADER   = 3'd2,
    ST_BAD_CHECKSUM = 3'd3,
    ST_OUT_OF_RANGE = 3'd4
  } status_t;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [15:0] ppm_min;
    logic [15:0] ppm_max;
  } cfg_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] ppm;
  } result_t;

endpackage

@@ hdl/gsfc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Configuration registers
// Timeout and concentration limits, written through the config channel.
// ----------------------------------------------------------------------------
module gsfc_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output gsfc_pkg::cfg_t      cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ticks <= gsfc_pkg::TIMEOUT_RESET;
      cfg.ppm_min       <= gsfc_pkg::PPM_MIN_RESET;
      cfg.ppm_max       <= gsfc_pkg::PPM_MAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gsfc_pkg::CFG_TIMEOUT: cfg.timeout_ticks <= cfg_data;
        gsfc_pkg::CFG_PPM_MIN: cfg.ppm_min       <= cfg_data;
        gsfc_pkg::CFG_PPM_MAX: cfg.ppm_max       <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ hdl/gsfc_frame_core.sv @@
// ----------------------------------------------------------------------------
// Frame core
// Input register, frame state and the combinational check of each registered request.
// ----------------------------------------------------------------------------
module gsfc_frame_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           cmd,
  input  logic [7:0]           data_byte,
  input  gsfc_pkg::cfg_t       cfg,
  input  logic                 res_ready,
  output logic                 res_valid,
  output gsfc_pkg::result_t    res
);

  localparam int IDX_W = gsfc_pkg::IDX_W;

  logic                 req_valid;
  logic                 req_valid_next;
  logic [1:0]           req_cmd;
  logic [7:0]           req_byte;
  logic                 go;

  logic                 frame_open;
  logic                 frame_open_next;
  logic [IDX_W-1:0]     byte_index;
  logic [IDX_W-1:0]     byte_index_next;
  logic [7:0]           running_sum;
  logic [7:0]           running_sum_next;
  logic                 header_good;
  logic                 header_good_next;
  logic [7:0]           value_high;
  logic [7:0]           value_high_next;
  logic [7:0]           value_low;
  logic [7:0]           value_low_next;
  logic [15:0]          ticks_left;
  logic [15:0]          ticks_left_next;

  logic [15:0]          ppm_val;
  logic [7:0]           expect_sum;

  assign go       = req_valid && res_ready;
  assign in_stall = req_valid && !res_ready;

  always_comb begin
    req_valid_next = req_valid;
    if (in_valid && !in_stall) begin
      req_valid_next = 1'b1;
    end else if (go) begin
      req_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= req_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_cmd  <= cmd;
      req_byte <= data_byte;
    end
  end

  assign ppm_val    = {value_high, value_low};
  assign expect_sum = 8'(8'd0 - running_sum);

  always_comb begin
    frame_open_next  = frame_open;
    byte_index_next  = byte_index;
    running_sum_next = running_sum;
    header_good_next = header_good;
    value_high_next  = value_high;
    value_low_next   = value_low;
    ticks_left_next  = ticks_left;
    res_valid        = 1'b0;
    res.status       = gsfc_pkg::ST_OK;
    res.ppm          = ppm_val;
    if (go) begin
      case (req_cmd)
        gsfc_pkg::CMD_START: begin
          frame_open_next  = 1'b1;
          byte_index_next  = '0;
          running_sum_next = '0;
          header_good_next = 1'b1;
          ticks_left_next  = cfg.timeout_ticks;
        end
        gsfc_pkg::CMD_TICK: begin
          if (frame_open) begin
            if (ticks_left[15:1] == 15'd0) begin
              ticks_left_next = '0;
              frame_open_next = 1'b0;
              res_valid       = 1'b1;
              res.status      = gsfc_pkg::ST_TIMEOUT;
              res.ppm         = '0;
            end else begin
              ticks_left_next = 16'(ticks_left - 16'd1);
            end
          end
        end
        gsfc_pkg::CMD_BYTE: begin
          if (frame_open) begin
            if (byte_index < IDX_W'(gsfc_pkg::FRAME_BYTES - 1)) begin
              if (byte_index == IDX_W'(0)) begin
                if (req_byte != gsfc_pkg::HDR_START) header_good_next = 1'b0;
              end else begin
                if (byte_index == IDX_W'(1) && req_byte != gsfc_pkg::HDR_CMD) begin
                  header_good_next = 1'b0;
                end
                if (byte_index == IDX_W'(2)) value_high_next = req_byte;
                if (byte_index == IDX_W'(3)) value_low_next  = req_byte;
                running_sum_next = 8'(running_sum + req_byte);
              end
              byte_index_next = IDX_W'(byte_index + IDX_W'(1));
            end else begin
              frame_open_next = 1'b0;
              byte_index_next = '0;
              res_valid       = 1'b1;
              if (!header_good) begin
                res.status = gsfc_pkg::ST_BAD_HEADER;
              end else if (req_byte != expect_sum) begin
                res.status = gsfc_pkg::ST_BAD_CHECKSUM;
              end else if (ppm_val < cfg.ppm_min || ppm_val > cfg.ppm_max) begin
                res.status = gsfc_pkg::ST_OUT_OF_RANGE;
              end else begin
                res.status = gsfc_pkg::ST_OK;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open  <= 1'b0;
      byte_index  <= '0;
      running_sum <= '0;
      header_good <= 1'b1;
      value_high  <= '0;
      value_low   <= '0;
      ticks_left  <= '0;
    end else begin
      frame_open  <= frame_open_next;
      byte_index  <= byte_index_next;
      running_sum <= running_sum_next;
      header_good <= header_good_next;
      value_high  <= value_high_next;
      value_low   <= value_low_next;
      ticks_left  <= ticks_left_next;
    end
  end

endmodule

@@ hdl/gsfc_out_reg.sv @@
// ----------------------------------------------------------------------------
// Result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module gsfc_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 res_valid,
  input  gsfc_pkg::result_t    res,
  output logic                 res_ready,
  output logic                 out_valid,
  input  logic                 out_stall,
  output gsfc_pkg::result_t    out_res
);

  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

endmodule

@@ hdl/gas_sensor_response_frame_checker_top.sv @@
// ----------------------------------------------------------------------------
// Gas sensor reply-frame checker
// Collects the nine-byte sensor reply, checks header, checksum and range,
// and reports one status per finished or timed-out frame.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  in        in_valid/in_stall    cmd[1:0], data_byte[7:0]
//  out       out_valid/out_stall  status[2:0], ppm[15:0]
//  cfg       cfg_valid/cfg_ready  cfg_index[1:0], cfg_data[15:0]
//
//  One request per cycle while in_stall is low; each result passes through
//  the input register, then the result register.
//  Reset clears frame state and loads the default limits.
//  in_stall rises only while the input register is full and the result
//  register is held by out_stall.
// ----------------------------------------------------------------------------
module gas_sensor_response_frame_checker_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [15:0] ppm,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  gsfc_pkg::cfg_t    cfg;
  gsfc_pkg::result_t res;
  gsfc_pkg::result_t out_res;
  logic              res_valid;
  logic              res_ready;

  gsfc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  gsfc_frame_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .data_byte (data_byte),
    .cfg       (cfg),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  gsfc_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign status = out_res.status;
  assign ppm    = out_res.ppm;

endmodule

@@ sim/tb_gas_sensor_response_frame_checker_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gas sensor reply-frame checker testbench
// Sends start, byte and tick requests to the checker. Most of them form whole
// nine-byte replies with random content and random flaws. The run steps
// through several timeout and range settings, extremes included. A local
// frame tracker predicts each status and reading, and every result is
// compared with it in order.
// ----------------------------------------------------------------------------
module tb_gas_sensor_response_frame_checker_top;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         TAIL_CYCLES = 4;

  typedef enum int {
    FLAW_NONE,
    FLAW_START_BYTE,
    FLAW_CMD_BYTE,
    FLAW_CHECKSUM,
    FLAW_HEADER_AND_SUM
  } flaw_t;

  typedef struct {
    logic [1:0] cmd;
    logic [7:0] octet;
  } sensor_req_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [1:0]  cmd       = CMD_UNUSED;
  logic [7:0]  data_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [15:0] ppm;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = gsfc_pkg::CFG_TIMEOUT;
  logic [15:0] cfg_data  = 16'd0;

  sensor_req_t         sensor_reqs[$];
  gsfc_pkg::result_t   verdicts[$];
  int                  reqs_queued = 0;
  int                  mismatches  = 0;

  // frame tracker state and its copy of the limits
  logic        rx_open;
  logic [3:0]  rx_count;
  logic [7:0]  rx_sum;
  logic        rx_hdr_ok;
  logic [7:0]  rx_hi;
  logic [7:0]  rx_lo;
  logic [15:0] rx_ticks;
  logic [15:0] lim_timeout;
  logic [15:0] lim_min;
  logic [15:0] lim_max;

  int burst_left = 0;
  int gap_left   = 0;
  int stall_mode = 0;
  int stall_run  = 0;

  gas_sensor_response_frame_checker_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .data_byte (data_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .ppm       (ppm),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic track_reply(input logic [1:0] c, input logic [7:0] b);
    gsfc_pkg::result_t r;
    logic [7:0]        want_sum;
    logic [15:0]       conc;
    if (c == gsfc_pkg::CMD_START) begin
      rx_open   = 1'b1;
      rx_count  = 4'd0;
      rx_sum    = 8'd0;
      rx_hdr_ok = 1'b1;
      rx_ticks  = lim_timeout;
    end else if (rx_open && c == gsfc_pkg::CMD_TICK) begin
      if (rx_ticks <= 16'd1) begin
        rx_ticks = 16'd0;
        rx_open  = 1'b0;
        r.status = gsfc_pkg::ST_TIMEOUT;
        r.ppm    = 16'd0;
        verdicts.push_back(r);
      end else begin
        rx_ticks = rx_ticks - 16'd1;
      end
    end else if (rx_open && c == gsfc_pkg::CMD_BYTE) begin
      if (rx_count < gsfc_pkg::FRAME_BYTES - 1) begin
        if (rx_count == 4'd0) begin
          if (b != gsfc_pkg::HDR_START) rx_hdr_ok = 1'b0;
        end else begin
          if (rx_count == 4'd1 && b != gsfc_pkg::HDR_CMD) rx_hdr_ok = 1'b0;
          if (rx_count == 4'd2) rx_hi = b;
          if (rx_count == 4'd3) rx_lo = b;
          rx_sum = rx_sum + b;
        end
        rx_count = rx_count + 4'd1;
      end else begin
        want_sum = 8'd0 - rx_sum;
        conc     = {rx_hi, rx_lo};
        if (!rx_hdr_ok) r.status = gsfc_pkg::ST_BAD_HEADER;
        else if (b != want_sum) r.status = gsfc_pkg::ST_BAD_CHECKSUM;
        else if (conc < lim_min || conc > lim_max) r.status = gsfc_pkg::ST_OUT_OF_RANGE;
        else r.status = gsfc_pkg::ST_OK;
        r.ppm    = conc;
        rx_open  = 1'b0;
        rx_count = 4'd0;
        verdicts.push_back(r);
      end
    end
  endtask

  // sender: bursts of random length, random gaps, some long unbroken runs
  always @(posedge clk) begin
    sensor_req_t r;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (sensor_reqs.size() > 0) begin
        r = sensor_reqs.pop_front();
        in_valid  <= 1'b1;
        cmd       <= r.cmd;
        data_byte <= r.octet;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(40, 120);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 8);
            gap_left   = $urandom_range(1, 6);
          end
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side: tracker update, compare, stall pattern
  always @(posedge clk) begin
    gsfc_pkg::result_t want;
    if (rst) begin
      out_stall   <= 1'b0;
      rx_open     = 1'b0;
      rx_count    = 4'd0;
      rx_sum      = 8'd0;
      rx_hdr_ok   = 1'b1;
      rx_hi       = 8'd0;
      rx_lo       = 8'd0;
      rx_ticks    = 16'd0;
      lim_timeout = gsfc_pkg::TIMEOUT_RESET;
      lim_min     = gsfc_pkg::PPM_MIN_RESET;
      lim_max     = gsfc_pkg::PPM_MAX_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gsfc_pkg::CFG_TIMEOUT: lim_timeout = cfg_data;
          gsfc_pkg::CFG_PPM_MIN: lim_min     = cfg_data;
          gsfc_pkg::CFG_PPM_MAX: lim_max     = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) track_reply(cmd, data_byte);
      if (out_valid && !out_stall) begin
        if (verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t mismatch: unexpected result status=%0d ppm=%0d",
                     $realtime, status, ppm);
        end else begin
          want = verdicts.pop_front();
          if (status !== want.status || ppm !== want.ppm) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t mismatch: status exp %0d got %0d, ppm exp %0d got %0d",
                       $realtime, want.status, status, want.ppm, ppm);
          end
        end
      end
      if (stall_run <= 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_run  = $urandom_range(5, 60);
      end
      stall_run = stall_run - 1;
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  task automatic push_req(input logic [1:0] c, input logic [7:0] b);
    sensor_req_t r;
    r.cmd   = c;
    r.octet = b;
    sensor_reqs.push_back(r);
    reqs_queued++;
  endtask

  task automatic push_frame(input logic [15:0] conc, input flaw_t flaw, input int tick_pct);
    logic [7:0] fb [gsfc_pkg::FRAME_BYTES];
    logic [7:0] s;
    int         i;
    fb[0] = gsfc_pkg::HDR_START;
    fb[1] = gsfc_pkg::HDR_CMD;
    fb[2] = conc[15:8];
    fb[3] = conc[7:0];
    for (i = 4; i < gsfc_pkg::FRAME_BYTES - 1; i++) fb[i] = 8'($urandom_range(0, 255));
    s = 8'd0;
    for (i = 1; i < gsfc_pkg::FRAME_BYTES - 1; i++) s = s + fb[i];
    fb[gsfc_pkg::FRAME_BYTES - 1] = 8'd0 - s;
    case (flaw)
      FLAW_START_BYTE: fb[0] ^= 8'($urandom_range(1, 255));
      FLAW_CMD_BYTE:   fb[1] ^= 8'($urandom_range(1, 255));
      FLAW_CHECKSUM:   fb[gsfc_pkg::FRAME_BYTES - 1] ^= 8'($urandom_range(1, 255));
      FLAW_HEADER_AND_SUM: begin
        fb[1] ^= 8'($urandom_range(1, 255));
        fb[gsfc_pkg::FRAME_BYTES - 1] ^= 8'($urandom_range(1, 255));
      end
      default: ;
    endcase
    push_req(gsfc_pkg::CMD_START, 8'($urandom_range(0, 255)));
    for (i = 0; i < gsfc_pkg::FRAME_BYTES; i++) begin
      if ($urandom_range(0, 99) < tick_pct)
        push_req(gsfc_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 49) == 0) push_req(CMD_UNUSED, 8'($urandom_range(0, 255)));
      push_req(gsfc_pkg::CMD_BYTE, fb[i]);
    end
  endtask

  function automatic logic [15:0] pick_conc();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return lim_min;
      3: return lim_max;
      4: return lim_min - 16'd1;
      5: return lim_max + 16'd1;
      default: begin
        if (lim_min <= lim_max) return 16'($urandom_range(lim_min, lim_max));
        return 16'($urandom_range(0, 16'hFFFF));
      end
    endcase
  endfunction

  task automatic run_phase(input int n_items, input int tick_pct);
    int target;
    int k;
    target = reqs_queued + n_items;
    while (reqs_queued < target) begin
      case ($urandom_range(0, 11))
        0: begin
          case ($urandom_range(0, 2))
            0:       push_req(gsfc_pkg::CMD_BYTE, 8'($urandom_range(0, 255)));
            1:       push_req(gsfc_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
            default: push_req(CMD_UNUSED, 8'($urandom_range(0, 255)));
          endcase
        end
        1: begin
          // partial frame, left open for a restart or run into its timeout
          push_req(gsfc_pkg::CMD_START, 8'($urandom_range(0, 255)));
          k = $urandom_range(0, gsfc_pkg::FRAME_BYTES - 1);
          repeat (k) push_req(gsfc_pkg::CMD_BYTE, 8'($urandom_range(0, 255)));
          if (lim_timeout <= 16'd16)
            repeat (lim_timeout + 1)
              push_req(gsfc_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
        end
        2, 3, 4: push_frame(pick_conc(), flaw_t'($urandom_range(1, 4)), tick_pct);
        default: push_frame(pick_conc(), FLAW_NONE, tick_pct);
      endcase
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (sensor_reqs.size() != 0 || in_valid || verdicts.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
  endtask

  task automatic set_limits(input logic [15:0] t, input logic [15:0] lo, input logic [15:0] hi);
    write_reg(gsfc_pkg::CFG_TIMEOUT, t);
    write_reg(gsfc_pkg::CFG_PPM_MIN, lo);
    write_reg(gsfc_pkg::CFG_PPM_MAX, hi);
  endtask

  initial begin : stimulus
    logic [15:0] lo;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset limits: ignored requests, reply at the lower limit, header over checksum
    push_req(gsfc_pkg::CMD_BYTE, gsfc_pkg::HDR_START);
    push_req(gsfc_pkg::CMD_TICK, 8'h55);
    push_req(CMD_UNUSED, 8'hAA);
    push_frame(gsfc_pkg::PPM_MIN_RESET, FLAW_NONE, 0);
    push_frame(gsfc_pkg::PPM_MAX_RESET + 16'd1, FLAW_HEADER_AND_SUM, 0);
    wait_idle();

    // zero timeout: first tick in a frame times out
    set_limits(16'd0, 16'd0, 16'hFFFF);
    push_req(gsfc_pkg::CMD_START, 8'h00);
    push_req(gsfc_pkg::CMD_TICK, 8'hFF);
    push_req(gsfc_pkg::CMD_BYTE, gsfc_pkg::HDR_START);
    run_phase(70, 20);
    wait_idle();

    set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_phase(60, 10);
    wait_idle();

    set_limits(16'd3, 16'd0, 16'd0);
    run_phase(60, 30);
    wait_idle();

    // inverted limits
    set_limits(16'($urandom_range(4, 40)), 16'd5000, 16'd200);
    run_phase(60, 15);
    wait_idle();

    lo = 16'($urandom_range(0, 30000));
    set_limits(16'd1, lo, lo + 16'($urandom_range(0, 30000)));
    run_phase(60, 5);
    wait_idle();

    set_limits(gsfc_pkg::TIMEOUT_RESET, gsfc_pkg::PPM_MIN_RESET, gsfc_pkg::PPM_MAX_RESET);
    run_phase(50, 5);
    wait_idle();

    if (mismatches == 0 && verdicts.size() == 0) begin
      $display("PASS gas_sensor_response_frame_checker_top");
    end else begin
      $display("FAIL gas_sensor_response_frame_checker_top");
    end
    $finish;
  end

  initial begin : watchdog
    #400000;
    $display("FAIL gas_sensor_response_frame_checker_top");
    $finish;
  end

endmodule

@@ gas_sensor_response_frame_checker_top.f @@
hdl/gsfc_pkg.sv
hdl/gsfc_cfg_regs.sv
hdl/gsfc_frame_core.sv
hdl/gsfc_out_reg.sv
hdl/gas_sensor_response_frame_checker_top.sv
sim/tb_gas_sensor_response_frame_checker_top.sv
